// ===== src/pblr_pkg.sv =====
// pblr_pkg: shared types and constants of the page buffer line rasterizer
// command and page byte payloads, request codes, column store access struct
// no dependencies
package pblr_pkg;

	localparam int REQ_W   = 3;
	localparam int COL_W   = 6;
	localparam int ROW_W   = 6;
	localparam int LEN_W   = 7;
	localparam int PAGE_W  = 3;
	localparam int PIX_W   = 8;
	localparam int RBIT_W  = 3;

	localparam int NUM_COLUMNS_DEF = 64;
	localparam int NUM_PAGES_DEF   = 4;

	localparam logic [PIX_W-1:0] CLEAR_BYTE = 8'h00;

	// request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_PIXEL  = 3'd0,
		REQ_HRUN   = 3'd1,
		REQ_VRUN   = 3'd2,
		REQ_FLUSH  = 3'd3,
		REQ_REWIND = 3'd4
	} req_code_t;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [COL_W-1:0] x;
		logic [ROW_W-1:0] y;
		logic [LEN_W-1:0] run_length;
	} cmd_t;

	typedef struct packed {
		logic [COL_W-1:0]  column;
		logic [PAGE_W-1:0] page_number;
		logic [PIX_W-1:0]  pixel_byte;
		logic              last_of_run;
		logic              more_pages;
	} page_byte_t;

	// one read port and one write port of the column store
	typedef struct packed {
		logic             rd_en;
		logic             rd_clr;
		logic [COL_W-1:0] rd_addr;
		logic             wr_en;
		logic [COL_W-1:0] wr_addr;
		logic [PIX_W-1:0] wr_data;
	} store_req_t;

endpackage

// ===== src/page_buffer_line_rasterizer.sv =====
// Page buffer line rasterizer: builds one eight-row page of a monochrome display
// and streams it out column by column on a flush. A pixel or a vertical run reads
// and rewrites its one column of the store; a horizontal run does so for each
// drawn column after clipping; commands that draw nothing, rewinds and unused
// codes are done in the cycle they are taken. A flush walks all NUM_COLUMNS
// column bytes through the single read port of the column store, one byte per
// cycle while the sink keeps taking them; the walk waits while the sink holds off.
// The last byte may still wait at the output while the next command is taken.
// The store reads as clear right after reset through per-column valid bits, so no
// clearing pass is needed. Depends on pblr_pkg and pblr_store.
module page_buffer_line_rasterizer #(
	parameter int NUM_COLUMNS = pblr_pkg::NUM_COLUMNS_DEF,
	parameter int NUM_PAGES   = pblr_pkg::NUM_PAGES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  pblr_pkg::cmd_t        cmd,
	output logic                  byte_valid,
	input  logic                  byte_ready,
	output pblr_pkg::page_byte_t  page_byte
);
	import pblr_pkg::*;

	localparam int PG_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam logic [COL_W-1:0] LAST_COL  = COL_W'(NUM_COLUMNS - 1);
	localparam logic [PG_W-1:0]  LAST_PAGE = PG_W'(NUM_PAGES - 1);
	localparam logic [LEN_W-1:0] COLS_EXT  = LEN_W'(NUM_COLUMNS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAW,
		ST_FLUSH
	} state_t;

	state_t           state_q;
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] last_q;
	logic [PIX_W-1:0] mask_q;
	logic [PG_W-1:0]  page_q;
	logic [PG_W-1:0]  flush_page_q;
	logic             issued_all_q;
	logic             pend_q;
	logic [COL_W-1:0] pend_col_q;
	logic             wr_s1;
	logic [COL_W-1:0] wr_col_s1;
	logic             obuf_valid_q;
	page_byte_t       obuf_q;

	logic [PAGE_W-1:0] page_ext;
	logic              in_page;
	logic [PIX_W-1:0]  pix_mask;
	logic [PIX_W-1:0]  vrun_mask;
	logic [PIX_W-1:0]  draw_mask;
	logic [LEN_W:0]    y_end;
	logic [LEN_W-1:0]  draw_cnt;
	logic [LEN_W:0]    draw_sum;
	logic [LEN_W-1:0]  draw_end;
	logic [COL_W-1:0]  draw_last;
	logic              draw_go;
	logic              cmd_xfer;
	logic              load;
	logic              issue;
	logic [PIX_W-1:0]  rd_data;
	store_req_t        store_req;

	// column store
	pblr_store #(
		.NUM_COLUMNS(NUM_COLUMNS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (store_req),
		.rd_data(rd_data)
	);

	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_xfer  = cmd_valid && cmd_ready;

	// row mask of one pixel in the current page
	assign page_ext = PAGE_W'(page_q);
	assign in_page  = (cmd.y[ROW_W-1:RBIT_W] == page_ext);
	assign pix_mask = in_page ? (PIX_W'(1) << cmd.y[RBIT_W-1:0]) : CLEAR_BYTE;

	// vertical run: rows of this page inside [y, y + run_length)
	assign y_end = {2'b0, cmd.y} + {1'b0, cmd.run_length};
	always_comb begin
		for (int b = 0; b < PIX_W; b++) begin
			vrun_mask[b] = ({1'b0, page_ext, RBIT_W'(b)} >= {1'b0, cmd.y})
				&& ({2'b0, page_ext, RBIT_W'(b)} < y_end);
		end
	end

	// column range of the draw, clipped at the right edge
	assign draw_cnt  = (cmd.req_type == REQ_HRUN) ? cmd.run_length : LEN_W'(1);
	assign draw_sum  = {2'b0, cmd.x} + {1'b0, draw_cnt};
	assign draw_end  = (draw_sum > {1'b0, COLS_EXT}) ? COLS_EXT : draw_sum[LEN_W-1:0];
	assign draw_last = COL_W'(draw_end - LEN_W'(1));
	assign draw_mask = (cmd.req_type == REQ_VRUN) ? vrun_mask : pix_mask;
	assign draw_go   = ({1'b0, cmd.x} < draw_end) && (draw_mask != CLEAR_BYTE);

	// flush streaming: a read is issued when its byte has somewhere to go
	assign load  = pend_q && (!obuf_valid_q || byte_ready);
	assign issue = (state_q == ST_FLUSH) && !issued_all_q && (!pend_q || load);

	// store port: draw read-modify-write or flush read-and-clear
	always_comb begin
		store_req.rd_en   = (state_q == ST_DRAW) || issue;
		store_req.rd_clr  = issue;
		store_req.rd_addr = col_q;
		store_req.wr_en   = wr_s1;
		store_req.wr_addr = wr_col_s1;
		store_req.wr_data = rd_data | mask_q;
	end

	// sequencer, column walker and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			col_q        <= '0;
			last_q       <= '0;
			mask_q       <= CLEAR_BYTE;
			page_q       <= '0;
			flush_page_q <= '0;
			issued_all_q <= 1'b0;
			pend_q       <= 1'b0;
			pend_col_q   <= '0;
			wr_s1        <= 1'b0;
			wr_col_s1    <= '0;
			obuf_valid_q <= 1'b0;
			obuf_q       <= '0;
		end else begin
			wr_s1     <= (state_q == ST_DRAW);
			wr_col_s1 <= col_q;

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_xfer) begin
						unique case (cmd.req_type)
							REQ_PIXEL, REQ_HRUN, REQ_VRUN: begin
								if (draw_go) begin
									col_q   <= cmd.x;
									last_q  <= draw_last;
									mask_q  <= draw_mask;
									state_q <= ST_DRAW;
								end
							end
							REQ_FLUSH: begin
								col_q        <= '0;
								issued_all_q <= 1'b0;
								flush_page_q <= page_q;
								page_q       <= (page_q == LAST_PAGE) ? '0 : page_q + PG_W'(1);
								state_q      <= ST_FLUSH;
							end
							REQ_REWIND: begin
								page_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_DRAW: begin
					col_q <= col_q + COL_W'(1);
					if (col_q == last_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (issue) begin
						col_q <= col_q + COL_W'(1);
						if (col_q == LAST_COL) begin
							issued_all_q <= 1'b1;
						end
					end
					if (issued_all_q && !pend_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// byte read from the store, waiting for the output register
			if (issue) begin
				pend_q     <= 1'b1;
				pend_col_q <= col_q;
			end else if (load) begin
				pend_q <= 1'b0;
			end

			// output register
			if (load) begin
				obuf_valid_q        <= 1'b1;
				obuf_q.column       <= pend_col_q;
				obuf_q.page_number  <= PAGE_W'(flush_page_q);
				obuf_q.pixel_byte   <= rd_data;
				obuf_q.last_of_run  <= (pend_col_q == LAST_COL);
				obuf_q.more_pages   <= (flush_page_q != LAST_PAGE);
			end else if (byte_ready) begin
				obuf_valid_q <= 1'b0;
			end
		end
	end

	assign byte_valid = obuf_valid_q;
	assign page_byte  = obuf_q;

endmodule

// ===== src/pblr_store.sv =====
// pblr_store: column byte store of one page, one read and one write port
// per-column valid bits make unwritten or flushed columns read as clear
// depends on pblr_pkg
module pblr_store #(
	parameter int NUM_COLUMNS = pblr_pkg::NUM_COLUMNS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pblr_pkg::store_req_t        req,
	output logic [pblr_pkg::PIX_W-1:0]  rd_data
);
	import pblr_pkg::*;

	localparam int AW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

	logic [PIX_W-1:0]       mem [NUM_COLUMNS];
	logic [PIX_W-1:0]       mem_rd_q;
	logic [NUM_COLUMNS-1:0] valid_q;
	logic                   rd_vld_q;

	// byte array, registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr[AW-1:0]] <= req.wr_data;
		end
		if (req.rd_en) begin
			mem_rd_q <= mem[req.rd_addr[AW-1:0]];
		end
	end

	// valid bits: set on write, dropped on a read that clears
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.rd_en) begin
				rd_vld_q <= valid_q[req.rd_addr[AW-1:0]];
			end
			if (req.rd_en && req.rd_clr) begin
				valid_q[req.rd_addr[AW-1:0]] <= 1'b0;
			end
			if (req.wr_en) begin
				valid_q[req.wr_addr[AW-1:0]] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_vld_q ? mem_rd_q : CLEAR_BYTE;

endmodule

// ===== src/pblr_checker.sv =====
// pblr_checker: port-level checks of the page buffer line rasterizer
// bound to the top level at the end of this file
// depends on pblr_pkg and page_buffer_line_rasterizer
module pblr_checker #(
	parameter int NUM_COLUMNS = pblr_pkg::NUM_COLUMNS_DEF,
	parameter int NUM_PAGES   = pblr_pkg::NUM_PAGES_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cmd_valid,
	input logic                  cmd_ready,
	input pblr_pkg::cmd_t        cmd,
	input logic                  byte_valid,
	input logic                  byte_ready,
	input pblr_pkg::page_byte_t  page_byte
);
	import pblr_pkg::*;

	// a stalled byte keeps its payload
	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_ready |=> byte_valid && $stable(page_byte))
		else $error("page byte changed while stalled");

	// a flush transfer busies the command side
	a_flush_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd.req_type == REQ_FLUSH) |=> !cmd_ready)
		else $error("command taken during flush");

	// a rewind finishes in its own cycle
	a_rewind_quick: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd.req_type == REQ_REWIND) |=> cmd_ready)
		else $error("rewind left the block busy");

	// last byte of a page sits at the rightmost column
	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && page_byte.last_of_run |->
			(page_byte.column == COL_W'(NUM_COLUMNS - 1)))
		else $error("last byte not at the rightmost column");

	// page number stays inside the display
	a_page_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid |-> (page_byte.page_number < PAGE_W'(NUM_PAGES - 1))
			|| (page_byte.page_number == PAGE_W'(NUM_PAGES - 1)))
		else $error("page number past the last page");

endmodule

bind page_buffer_line_rasterizer pblr_checker #(
	.NUM_COLUMNS(NUM_COLUMNS),
	.NUM_PAGES  (NUM_PAGES)
) u_pblr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.cmd       (cmd),
	.byte_valid(byte_valid),
	.byte_ready(byte_ready),
	.page_byte (page_byte)
);
